>>> hdl/gbfs_pkg.sv
// Shared types and constants of the grid breadth-first search block.
package gbfs_pkg;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 8;
  localparam int CELL_W   = 5;

  localparam logic [1:0] KIND_GRASS = 2'd0;
  localparam logic [1:0] KIND_CITY  = 2'd1;
  localparam logic [1:0] KIND_PATH  = 2'd2;
  localparam logic [1:0] KIND_WALL  = 2'd3;

  localparam logic [2:0] MOVE_UP    = 3'd0;
  localparam logic [2:0] MOVE_RIGHT = 3'd1;
  localparam logic [2:0] MOVE_DOWN  = 3'd2;
  localparam logic [2:0] MOVE_LEFT  = 3'd3;
  localparam logic [2:0] MOVE_NONE  = 3'd4;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  typedef struct packed {
    logic       occupied;
    logic       enemy_here;
    logic       owned_by_me;
    logic [1:0] cell_kind;
  } cell_t;

endpackage

>>> hdl/gbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/grid_bfs_first_step.sv
// Grid breadth-first search: cell loads and first-move queries over a stored grid.
// A query clears the visited memory and tests the start cell, then reads each dequeued
// cell and probes its in-bounds neighbors one at a time, since the cell memory has a
// single read port.
// Reset (synchronous, active high) restores 64 rows and 64 columns and idles
// the sequencer; the cell memory holds nothing defined until cells are loaded.
module grid_bfs_first_step #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata from bit 0: row[5:0], col[5:0], cell_kind[1:0], owned_by_me,
  // enemy_here, occupied, search_mode, zero fill.
  input  logic [gbfs_pkg::S_DATA_W-1:0] s_tdata,
  // tuser: action (0 load one cell, 1 run a query).
  input  logic                          s_tuser,
  // Result stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata from bit 0: first_move[2:0], zero fill.
  output logic [gbfs_pkg::M_DATA_W-1:0] m_tdata,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gbfs_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int QW    = RW + CW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_SCHK   = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_PWAIT  = 4'd5;
  localparam logic [3:0] S_CUR    = 4'd6;
  localparam logic [3:0] S_NBRD   = 4'd7;
  localparam logic [3:0] S_NBCHK  = 4'd8;
  localparam logic [3:0] S_RESULT = 4'd9;

  // Configuration registers. The word address selects the register; pready
  // is tied high, so every write completes in its access cycle.
  logic [6:0] grid_rows;
  logic [6:0] grid_cols;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) grid_rows <= pwdata[6:0];
      else                      grid_cols <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? {25'd0, grid_cols} : {25'd0, grid_rows};

  // Register values above the store size act as the store size.
  logic [RNW-1:0] rows_used;
  logic [CNW-1:0] cols_used;
  assign rows_used = ({2'b0, grid_rows} > 9'(MAX_ROWS)) ? RNW'(MAX_ROWS) : RNW'(grid_rows);
  assign cols_used = ({2'b0, grid_cols} > 9'(MAX_COLS)) ? CNW'(MAX_COLS) : CNW'(grid_cols);

  // Input field unpacking.
  logic [5:0] in_row;
  logic [5:0] in_col;
  cell_t      in_cell;
  logic       in_mode;
  assign in_row  = s_tdata[5:0];
  assign in_col  = s_tdata[11:6];
  assign in_cell = cell_t'(s_tdata[16:12]);
  assign in_mode = s_tdata[17];

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  function automatic logic target_of(input cell_t c, input logic enemy_mode);
    if (c.occupied)  target_of = 1'b0;
    else if (enemy_mode) target_of = c.enemy_here;
    else target_of = ((c.cell_kind == KIND_CITY) || (c.cell_kind == KIND_PATH)) &&
                     !c.owned_by_me;
  endfunction

  // Sequencer state.
  logic [3:0]    state;
  logic [AW-1:0] clr_cnt;
  logic [AW:0]   q_head;
  logic [AW:0]   q_tail;
  logic [RW-1:0] start_r;
  logic [CW-1:0] start_c;
  logic          mode;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic [1:0]    cur_dir;
  logic          cur_is_start;
  logic [1:0]    nb_d;
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  logic [2:0]    res_move;

  // Memories: the cell store, the visited map and the search queue.
  cell_t         cell_rdata;
  logic [4:0]    cell_rraw;
  logic          cell_we;
  logic [AW-1:0] cell_raddr;
  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;
  logic          vis_rdata;
  logic          q_we;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  logic          load_ok;
  logic          s_xfer;
  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign load_ok  = ({3'b0, in_row} < 9'(MAX_ROWS)) && ({3'b0, in_col} < 9'(MAX_COLS));
  assign cell_we  = s_xfer && (s_tuser == ACT_LOAD) && load_ok;

  // Queue entries hold row, column and the first move that led there.
  logic [RW-1:0] q_r;
  logic [CW-1:0] q_c;
  logic [1:0]    q_dir;
  assign q_r   = q_rdata[QW-1 -: RW];
  assign q_c   = q_rdata[CW+1:2];
  assign q_dir = q_rdata[1:0];

  // Neighbor selection for the current probe direction.
  logic          nb_ok;
  logic [RW-1:0] nb_r_sel;
  logic [CW-1:0] nb_c_sel;
  always_comb begin
    nb_ok    = 1'b0;
    nb_r_sel = cur_r;
    nb_c_sel = cur_c;
    case (nb_d)
      MOVE_UP[1:0]: begin
        nb_ok    = (cur_r != '0);
        nb_r_sel = RW'(cur_r - 1'b1);
      end
      MOVE_RIGHT[1:0]: begin
        nb_ok    = (CNW'(cur_c) + 1'b1) < cols_used;
        nb_c_sel = CW'(CNW'(cur_c) + 1'b1);
      end
      MOVE_DOWN[1:0]: begin
        nb_ok    = (RNW'(cur_r) + 1'b1) < rows_used;
        nb_r_sel = RW'(RNW'(cur_r) + 1'b1);
      end
      default: begin
        nb_ok    = (cur_c != '0);
        nb_c_sel = CW'(cur_c - 1'b1);
      end
    endcase
  end

  // A neighbor enters the queue when it is passable and not yet visited.
  logic nb_push;
  assign nb_push = (state == S_NBCHK) && (cell_rdata.cell_kind != KIND_WALL) &&
                   !cell_rdata.occupied && !vis_rdata;

  // Cell read address: the start cell, the dequeued cell or a neighbor.
  always_comb begin
    case (state)
      S_START: cell_raddr = cell_addr(start_r, start_c);
      S_PWAIT: cell_raddr = cell_addr(q_r, q_c);
      default: cell_raddr = cell_addr(nb_r_sel, nb_c_sel);
    endcase
  end

  // Visited write port: the clearing sweep, the start mark and neighbor marks.
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cell_addr(nb_r, nb_c);
    vis_wdata = 1'b1;
    case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_cnt;
        vis_wdata = 1'b0;
      end
      S_SCHK: begin
        vis_we    = !target_of(cell_rdata, mode);
        vis_waddr = cell_addr(start_r, start_c);
      end
      S_NBCHK: vis_we = nb_push;
      default: vis_we = 1'b0;
    endcase
  end

  always_comb begin
    q_we    = 1'b0;
    q_wdata = {start_r, start_c, MOVE_UP[1:0]};
    case (state)
      S_SCHK:  q_we = !target_of(cell_rdata, mode);
      S_NBCHK: begin
        q_we    = nb_push;
        q_wdata = {nb_r, nb_c, cur_is_start ? nb_d : cur_dir};
      end
      default: q_we = 1'b0;
    endcase
  end

  gbfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_addr(RW'(in_row), CW'(in_col))),
    .wdata (5'(in_cell)),
    .raddr (cell_raddr),
    .rdata (cell_rraw)
  );
  assign cell_rdata = cell_t'(cell_rraw);

  gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (cell_addr(nb_r_sel, nb_c_sel)),
    .rdata (vis_rdata)
  );

  gbfs_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail[AW-1:0]),
    .wdata (q_wdata),
    .raddr (q_head[AW-1:0]),
    .rdata (q_rdata)
  );

  // Main sequencer. Each visited write lands before the next probe reads, so
  // no forwarding is needed on the visited map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      q_head   <= '0;
      q_tail   <= '0;
      clr_cnt  <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESULT)) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_xfer && (s_tuser == ACT_QUERY)) begin
            start_r <= RW'(in_row);
            start_c <= CW'(in_col);
            mode    <= in_mode;
            clr_cnt <= '0;
            // The start entry is written at the queue's first slot.
            q_head  <= '0;
            q_tail  <= '0;
            if (({3'b0, in_row} < 9'(rows_used)) && ({3'b0, in_col} < 9'(cols_used))) begin
              state <= S_CLEAR;
            end else begin
              res_move <= MOVE_NONE;
              state    <= S_RESULT;
            end
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(CELLS - 1)) state <= S_START;
        end
        S_START: state <= S_SCHK;
        S_SCHK: begin
          if (target_of(cell_rdata, mode)) begin
            res_move <= MOVE_UP;
            state    <= S_RESULT;
          end else begin
            q_head <= '0;
            q_tail <= (AW+1)'(1);
            state  <= S_POP;
          end
        end
        S_POP: begin
          if (q_head == q_tail) begin
            res_move <= MOVE_NONE;
            state    <= S_RESULT;
          end else begin
            q_head <= q_head + 1'b1;
            state  <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          cur_r        <= q_r;
          cur_c        <= q_c;
          cur_dir      <= q_dir;
          cur_is_start <= (q_r == start_r) && (q_c == start_c);
          state        <= S_CUR;
        end
        S_CUR: begin
          nb_d <= MOVE_UP[1:0];
          if (!cur_is_start && target_of(cell_rdata, mode)) begin
            res_move <= {1'b0, cur_dir};
            state    <= S_RESULT;
          end else if (!cur_is_start && !mode &&
                       ((cell_rdata.cell_kind == KIND_CITY) ||
                        (cell_rdata.cell_kind == KIND_PATH))) begin
            state <= S_POP;
          end else begin
            state <= S_NBRD;
          end
        end
        S_NBRD: begin
          nb_r <= nb_r_sel;
          nb_c <= nb_c_sel;
          if (nb_ok) begin
            state <= S_NBCHK;
          end else begin
            nb_d <= nb_d + 1'b1;
            if (nb_d == MOVE_LEFT[1:0]) state <= S_POP;
          end
        end
        S_NBCHK: begin
          if (nb_push) q_tail <= q_tail + 1'b1;
          nb_d  <= nb_d + 1'b1;
          state <= (nb_d == MOVE_LEFT[1:0]) ? S_POP : S_NBRD;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, res_move};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The read pointer never passes the write pointer.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) q_head <= q_tail)
    else $error("queue head passed tail");

  // Every cell enters the queue at most once, so the queue never overflows.
  a_tail_bound: assert property (@(posedge clk) disable iff (rst) q_tail <= (AW+1)'(CELLS))
    else $error("queue overflow");

  // A delivered move is a direction or the none code.
  a_move_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= MOVE_NONE))
    else $error("bad move code");

  // When the result slot is free, the result state raises m_tvalid and returns the sequencer to idle.
  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && (!m_tvalid || m_tready) |=> m_tvalid && (state == S_IDLE))
    else $error("result not delivered");

endmodule
